// ===== hdl/csma_bo_pkg.sv =====
// ----------------------------------------------------------------------------
// CSMA/CD transmit backoff - shared types and constants
// Transfer payloads, register map and reset values for the backoff core.
// ----------------------------------------------------------------------------
package csma_bo_pkg;

  // Width of the random fraction that is used for the slot count
  localparam int unsigned RandomBits = 10;
  // Hard cap on the backoff exponent
  localparam int unsigned MaxExp     = 10;

  localparam int unsigned SlotsW     = 10;
  localparam int unsigned TickW      = 16;
  localparam int unsigned AttW       = 5;
  localparam int unsigned ExpW       = 4;

  // Register map, word index
  localparam logic [1:0] RegCollWindow = 2'd0;
  localparam logic [1:0] RegSlotTicks  = 2'd1;
  localparam logic [1:0] RegMaxAtt     = 2'd2;
  localparam logic [1:0] RegExpLimit   = 2'd3;

  localparam logic [TickW-1:0] CollWindowRst = TickW'(150);
  localparam logic [TickW-1:0] SlotTicksRst  = TickW'(170);
  localparam logic [AttW-1:0]  MaxAttRst     = AttW'(16);
  localparam logic [ExpW-1:0]  ExpLimitRst   = ExpW'(10);

  typedef struct packed {
    logic       frame_pending;
    logic       channel_busy;
    logic       collision_seen;
    logic       jam_seen;
    logic [9:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic            transmitting;
    logic            jamming;
    logic            frame_sent;
    logic            frame_failed;
    logic            backing_off;
    logic [AttW-1:0] attempt_number;
  } out_item_t;

endpackage

// ===== hdl/csma_cd_transmit_backoff_core.sv =====
// ----------------------------------------------------------------------------
// CSMA/CD transmit backoff core
// One station's transmit controller with truncated binary exponential
// backoff, advanced by one tick per input transfer.
// ----------------------------------------------------------------------------
//  channel   signals                                 payload
//  input     in_valid_i / in_ready_o                 in_data_i  (in_item_t)
//  output    out_valid_o / out_ready_i               out_data_o (out_item_t)
//  config    psel, penable, pwrite, paddr, pready    pwdata / prdata
//
//  Each tick is one pass of logic between the state registers and the
//  result register, so a tick is accepted every cycle while the result
//  register is free or being drained.
//  Reset is asynchronous: idle, attempt count one, registers at defaults.
//  A stalled output holds its result and stops further input transfers.
// ----------------------------------------------------------------------------
module csma_cd_transmit_backoff_core
  import csma_bo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhTx      = 3'd1,
    PhJam     = 3'd2,
    PhBackoff = 3'd3
  } phase_e;

  // Configuration registers
  logic [TickW-1:0] coll_window_q, slot_ticks_q;
  logic [AttW-1:0]  max_att_q;
  logic [ExpW-1:0]  exp_limit_q;

  // Controller state
  phase_e            phase_q, phase_d;
  logic [TickW-1:0]  window_cnt_q, window_cnt_d;
  logic [SlotsW-1:0] slots_left_q, slots_left_d;
  logic [TickW-1:0]  slot_tick_q, slot_tick_d;
  logic [AttW-1:0]   attempts_q, attempts_d;
  logic              collided_q, collided_d;

  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;

  logic in_xfer;
  logic cfg_wr;

  // Backoff length
  logic [AttW-1:0]            bo_att;
  logic [ExpW-1:0]            bo_exp;
  logic [RandomBits-1:0]      bo_rnd;
  logic [RandomBits+MaxExp-1:0] bo_prod;
  logic [SlotsW-1:0]          bo_slots;

  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite;
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_comb begin
    case (paddr[3:2])
      RegCollWindow: prdata = {16'd0, coll_window_q};
      RegSlotTicks:  prdata = {16'd0, slot_ticks_q};
      RegMaxAtt:     prdata = {27'd0, max_att_q};
      RegExpLimit:   prdata = {28'd0, exp_limit_q};
      default:       prdata = 32'd0;
    endcase
  end

  // The jam tick backs off at the raised count, an idle jam at the current one
  always_comb begin
    logic [AttW:0] raised;
    raised = {1'b0, attempts_q} + 6'd1;
    bo_att = (phase_q == PhJam) ? raised[AttW-1:0] : attempts_q;
    if ({3'd0, bo_att} > {4'd0, exp_limit_q}) begin
      bo_exp = (exp_limit_q > ExpW'(MaxExp)) ? ExpW'(MaxExp) : exp_limit_q;
    end else begin
      bo_exp = (bo_att > AttW'(MaxExp)) ? ExpW'(MaxExp) : bo_att[ExpW-1:0];
    end
    bo_rnd   = in_data_i.random_fraction[RandomBits-1:0];
    bo_prod  = {{MaxExp{1'b0}}, bo_rnd} << bo_exp;
    bo_slots = SlotsW'(bo_prod >> RandomBits);
  end

  always_comb begin
    phase_e        ph;
    logic [AttW:0] next_att;
    logic          start_bo;

    ph           = phase_q;
    window_cnt_d = window_cnt_q;
    slots_left_d = slots_left_q;
    slot_tick_d  = slot_tick_q;
    attempts_d   = attempts_q;
    collided_d   = collided_q;
    start_bo     = 1'b0;
    next_att     = {1'b0, attempts_q} + 6'd1;
    out_data_d   = '0;

    case (phase_q)
      PhIdle, PhTx, PhJam, PhBackoff: ph = phase_q;
      default:                        ph = PhIdle;
    endcase

    if (ph == PhIdle && in_data_i.frame_pending) begin
      if (in_data_i.jam_seen) begin
        // An idle jam counts its first backoff tick right away
        slots_left_d = bo_slots;
        slot_tick_d  = '0;
        ph           = (bo_slots == '0) ? PhIdle : PhBackoff;
      end else if (!in_data_i.channel_busy) begin
        ph           = PhTx;
        window_cnt_d = '0;
        collided_d   = 1'b0;
      end
    end

    case (ph)
      PhTx: begin
        out_data_d.transmitting = 1'b1;
        if (window_cnt_d != '1) window_cnt_d = window_cnt_d + 1'b1;
        collided_d = collided_d | in_data_i.collision_seen;
        if (window_cnt_d >= coll_window_q) begin
          if (collided_d) begin
            ph = PhJam;
          end else begin
            out_data_d.frame_sent = 1'b1;
            attempts_d            = AttW'(1);
            ph                    = PhIdle;
          end
        end
      end
      PhJam: begin
        out_data_d.jamming = 1'b1;
        if (next_att > {1'b0, max_att_q}) begin
          out_data_d.frame_failed = 1'b1;
          attempts_d              = AttW'(1);
          ph                      = PhIdle;
        end else begin
          attempts_d = next_att[AttW-1:0];
          start_bo   = 1'b1;
        end
      end
      PhBackoff: begin
        out_data_d.backing_off = 1'b1;
        slot_tick_d = slot_tick_d + 1'b1;
        if (slot_tick_d >= slot_ticks_q) begin
          slot_tick_d = '0;
          if (slots_left_d != '0) slots_left_d = slots_left_d - 1'b1;
          if (slots_left_d == '0) ph = PhIdle;
        end
      end
      default: ;
    endcase

    // After a jam tick, backoff starts on the following tick
    if (start_bo) begin
      slots_left_d = bo_slots;
      slot_tick_d  = '0;
      ph           = (bo_slots == '0) ? PhIdle : PhBackoff;
    end

    out_data_d.attempt_number = attempts_d;
    phase_d = ph;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_window_q <= CollWindowRst;
      slot_ticks_q  <= SlotTicksRst;
      max_att_q     <= MaxAttRst;
      exp_limit_q   <= ExpLimitRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegCollWindow: coll_window_q <= pwdata[TickW-1:0];
        RegSlotTicks:  slot_ticks_q  <= pwdata[TickW-1:0];
        RegMaxAtt:     max_att_q     <= pwdata[AttW-1:0];
        RegExpLimit:   exp_limit_q   <= pwdata[ExpW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      window_cnt_q <= '0;
      slots_left_q <= '0;
      slot_tick_q  <= '0;
      attempts_q   <= AttW'(1);
      collided_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_q      <= phase_d;
        window_cnt_q <= window_cnt_d;
        slots_left_q <= slots_left_d;
        slot_tick_q  <= slot_tick_d;
        attempts_q   <= attempts_d;
        collided_q   <= collided_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_xfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("accepted tick gave no result");

  a_one_activity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.transmitting, out_data_o.jamming,
                                out_data_o.backing_off}) <= 1)
    else $error("more than one activity in one tick");

  a_sent_while_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_sent) |-> out_data_o.transmitting)
    else $error("frame_sent outside a transmit tick");

  a_fail_while_jam: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_failed) |->
      (out_data_o.jamming && out_data_o.attempt_number == AttW'(1)))
    else $error("frame_failed outside a jam tick or count not restarted");

  a_att_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    attempts_q != '0)
    else $error("attempt count reached zero");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CSMA/CD transmit backoff core
// Steps the station tick by tick over valid/ready, reprogrammes the timing
// registers between phases over APB, and checks every result transfer
// against a cycle-free model of the transmit, jam and backoff sequencing.
// ----------------------------------------------------------------------------
module tb_top;
  import csma_bo_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned LongHoldCycles = 300;

  typedef enum logic [2:0] {TxIdle, TxSend, TxJam, TxBackoff} tx_phase_e;

  typedef struct {
    bit          is_write;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    in_item_t    tick;
    bit          typed;
    out_item_t   want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Station model: timing registers and sequencing state
  logic [15:0] cf_window    = CollWindowRst;
  logic [15:0] cf_slot      = SlotTicksRst;
  logic [4:0]  cf_max_att   = MaxAttRst;
  logic [3:0]  cf_exp_limit = ExpLimitRst;

  tx_phase_e   st_phase      = TxIdle;
  logic [15:0] st_window     = '0;
  logic [9:0]  st_slots      = '0;
  logic [15:0] st_slot_ticks = '0;
  logic [4:0]  st_att        = 5'd1;
  logic        st_collided   = 1'b0;

  out_item_t   station_outputs_q[$];
  script_row_t script[$];
  int unsigned mismatches = 0;
  int unsigned ticks_accepted = 0;
  int unsigned burst_left = 0;
  int unsigned cycles = 0;

  csma_cd_transmit_backoff_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_item_t tick_in(bit pend, bit busy, bit coll, bit jam,
                                       logic [9:0] frac);
    in_item_t t;
    t.frame_pending   = pend;
    t.channel_busy    = busy;
    t.collision_seen  = coll;
    t.jam_seen        = jam;
    t.random_fraction = frac;
    return t;
  endfunction

  function automatic out_item_t tick_out(bit tx, bit jm, bit sent, bit failed, bit bo,
                                         logic [4:0] att);
    out_item_t r;
    r.transmitting   = tx;
    r.jamming        = jm;
    r.frame_sent     = sent;
    r.frame_failed   = failed;
    r.backing_off    = bo;
    r.attempt_number = att;
    return r;
  endfunction

  // Slot count is floor(2^k * frac / 2^10), k capped by the limit and by ten
  function automatic void load_backoff(logic [9:0] frac);
    int unsigned k;
    logic [19:0] scaled;
    k = st_att;
    if (k > cf_exp_limit) k = cf_exp_limit;
    if (k > MaxExp) k = MaxExp;
    scaled = {10'd0, frac} << k;
    st_slots = scaled[19:10];
    st_slot_ticks = '0;
    st_phase = (st_slots == '0) ? TxIdle : TxBackoff;
  endfunction

  function automatic out_item_t step_station(in_item_t t);
    out_item_t r;
    int unsigned next_att;
    r = '0;
    if (st_phase == TxIdle && t.frame_pending) begin
      if (t.jam_seen) begin
        load_backoff(t.random_fraction);
      end else if (!t.channel_busy) begin
        st_phase = TxSend;
        st_window = '0;
        st_collided = 1'b0;
      end
    end
    // a backoff entered from idle counts its first tick right away
    case (st_phase)
      TxSend: begin
        r.transmitting = 1'b1;
        if (st_window != 16'hFFFF) st_window = st_window + 16'd1;
        st_collided = st_collided | t.collision_seen;
        if (st_window >= cf_window) begin
          if (st_collided) begin
            st_phase = TxJam;
          end else begin
            r.frame_sent = 1'b1;
            st_att = 5'd1;
            st_phase = TxIdle;
          end
        end
      end
      TxJam: begin
        next_att = st_att + 1;
        r.jamming = 1'b1;
        if (next_att > cf_max_att) begin
          r.frame_failed = 1'b1;
          st_att = 5'd1;
          st_phase = TxIdle;
        end else begin
          st_att = 5'(next_att);
          load_backoff(t.random_fraction);
        end
      end
      TxBackoff: begin
        r.backing_off = 1'b1;
        st_slot_ticks = st_slot_ticks + 16'd1;
        if (st_slot_ticks >= cf_slot) begin
          st_slot_ticks = '0;
          if (st_slots != '0) st_slots = st_slots - 10'd1;
          if (st_slots == '0) st_phase = TxIdle;
        end
      end
      default: ;
    endcase
    r.attempt_number = st_att;
    return r;
  endfunction

  function automatic in_item_t random_tick(int unsigned coll_pct);
    logic [9:0] frac;
    // small fractions keep backoffs short so the attempt count can climb
    frac = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 15));
    return tick_in($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 20,
                   $urandom_range(0, 99) < coll_pct, $urandom_range(0, 99) < 8, frac);
  endfunction

  function automatic void add_tick(in_item_t t, bit typed = 1'b0, out_item_t w = '0);
    script_row_t row;
    row = '{is_write: 1'b0, reg_idx: '0, value: '0, tick: t, typed: typed, want: w};
    script.push_back(row);
  endfunction

  function automatic void add_write(logic [1:0] idx, logic [31:0] val);
    script_row_t row;
    row = '{is_write: 1'b1, reg_idx: idx, value: val, tick: '0, typed: 1'b0, want: '0};
    script.push_back(row);
  endfunction

  task automatic offer_tick(in_item_t t, bit typed, out_item_t w);
    int unsigned gap;
    out_item_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predicted = step_station(t);
    station_outputs_q.push_back(typed ? w : predicted);
    ticks_accepted++;
  endtask

  // Hold the input until every outstanding result has drained
  task automatic wait_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    while (station_outputs_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegCollWindow: cf_window    = val[15:0];
      RegSlotTicks:  cf_slot      = val[15:0];
      RegMaxAtt:     cf_max_att   = val[4:0];
      RegExpLimit:   cf_exp_limit = val[3:0];
      default: ;
    endcase
    // read back through the same port
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== val) begin
      $error("register %0d readback: expected %0d, got %0d", idx, val, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timing(logic [15:0] win, logic [15:0] slot, logic [4:0] max_att,
                            logic [3:0] exp_limit);
    write_reg(RegCollWindow, 32'(win));
    write_reg(RegSlotTicks, 32'(slot));
    write_reg(RegMaxAtt, 32'(max_att));
    write_reg(RegExpLimit, 32'(exp_limit));
  endtask

  task automatic run_random(int unsigned count, int unsigned coll_pct);
    repeat (count) offer_tick(random_tick(coll_pct), 1'b0, '0);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (station_outputs_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatches++;
      end else begin
        want = station_outputs_q.pop_front();
        check_field("transmitting", want.transmitting, out_data.transmitting);
        check_field("jamming", want.jamming, out_data.jamming);
        check_field("frame_sent", want.frame_sent, out_data.frame_sent);
        check_field("frame_failed", want.frame_failed, out_data.frame_failed);
        check_field("backing_off", want.backing_off, out_data.backing_off);
        check_field("attempt_number", want.attempt_number, out_data.attempt_number);
      end
    end
  end

  // Receiver: random stall patterns, plus one long hold to fill the core
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && ticks_accepted >= 400) begin
      hold_done = 1'b1;
      hold_left = LongHoldCycles;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // at reset values: no frame, carrier held off, jam with zero slots
    add_tick(tick_in(0, 1, 1, 1, 10'h3FF), 1'b1, tick_out(0, 0, 0, 0, 0, 5'd1));
    add_tick(tick_in(1, 1, 0, 0, 10'h155), 1'b1, tick_out(0, 0, 0, 0, 0, 5'd1));
    add_tick(tick_in(1, 0, 0, 1, 10'h000), 1'b1, tick_out(0, 0, 0, 0, 0, 5'd1));
    add_write(RegCollWindow, 32'd2);
    add_write(RegSlotTicks, 32'd1);
    add_write(RegMaxAtt, 32'd2);
    add_write(RegExpLimit, 32'd10);
    // clean frame
    add_tick(tick_in(1, 0, 0, 0, 10'h2AA));
    add_tick(tick_in(0, 0, 0, 0, 10'h000), 1'b1, tick_out(1, 0, 1, 0, 0, 5'd1));
    // collision, jam, three slots of backoff with pending ignored
    add_tick(tick_in(1, 0, 1, 0, 10'h000));
    add_tick(tick_in(0, 1, 0, 1, 10'h000));
    add_tick(tick_in(0, 0, 0, 0, 10'h3FF));
    add_tick(tick_in(1, 0, 0, 0, 10'h000));
    add_tick(tick_in(1, 0, 0, 0, 10'h000));
    add_tick(tick_in(1, 0, 0, 0, 10'h000));
    // second collision exceeds the attempt limit
    add_tick(tick_in(1, 0, 1, 0, 10'h000));
    add_tick(tick_in(0, 0, 0, 0, 10'h000));
    add_tick(tick_in(0, 0, 0, 0, 10'h3FF), 1'b1, tick_out(0, 1, 0, 1, 0, 5'd1));
    // jam while waiting: one slot of backoff, then a clean frame
    add_tick(tick_in(1, 0, 0, 1, 10'h200));
    add_tick(tick_in(1, 0, 0, 0, 10'h000));
    add_tick(tick_in(0, 0, 0, 0, 10'h000));

    foreach (script[i]) begin
      if (script[i].is_write) write_reg(script[i].reg_idx, script[i].value);
      else offer_tick(script[i].tick, script[i].typed, script[i].want);
    end

    set_timing(16'd3, 16'd2, 5'd4, 4'd3);
    run_random(180, 25);
    set_timing(16'd1, 16'd1, 5'd1, 4'd1);
    run_random(150, 30);
    // out-of-range values: zero window, slot, attempts and exponent
    set_timing(16'd0, 16'd0, 5'd0, 4'd0);
    run_random(120, 30);
    set_timing(16'd5, 16'd1, 5'd31, 4'd10);
    run_random(220, 60);
    set_timing(16'd2, 16'd3, 5'd8, 4'd15);
    run_random(160, 35);
    set_timing(16'd1, 16'd1, 5'd16, 4'd10);
    run_random(200, 40);
    set_timing(16'hFFFF, 16'hFFFF, 5'd31, 4'd10);
    run_random(80, 30);
    set_timing(16'd4, 16'd2, 5'd16, 4'd10);
    run_random(100, 30);

    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
